// ===== hw/rtl/shared_buffer_multi_queue_core_assert.svh =====
// Assertion macros used by the RTL core.
`ifndef SHARED_BUFFER_MULTI_QUEUE_CORE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_CORE_ASSERT_SVH

// Implication checked every edge outside reset.
`define SBMQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked every edge outside reset.
`define SBMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbmq_pkg.sv =====
`timescale 1ns / 1ps
package sbmq_pkg;
    localparam int NumBlocks  = 255;
    localparam int BlockBytes = 8;
    localparam int StoreBytes = NumBlocks * BlockBytes;
    localparam int AddrW      = $clog2(StoreBytes);
    localparam int OffW       = $clog2(BlockBytes);
    localparam logic [7:0] EndMark = 8'hFF;

    typedef logic [1:0] t_mode;
    localparam t_mode ModeCreate  = 2'd0;
    localparam t_mode ModeDestroy = 2'd1;
    localparam t_mode ModeEnq     = 2'd2;
    localparam t_mode ModeDeq     = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status StOk      = 2'd0;
    localparam t_status StNoMem   = 2'd1;
    localparam t_status StIllegal = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,       // issue read of r_addr
        S_WAIT,     // memory latency
        S_EXEC,     // consume read data
        S_WR,       // write r_waddr/r_wdata, go to r_ret
        S_OUT
    } t_state;

    function automatic logic [AddrW-1:0] addr_of(input logic [7:0] blk, input logic [7:0] off);
        logic [AddrW+8:0] a;
        a = (AddrW+9)'(blk) * (AddrW+9)'(BlockBytes) + (AddrW+9)'(off);
        return AddrW'(a);
    endfunction

    function automatic logic blk_ok(input logic [7:0] b);
        return 32'(b) < NumBlocks;
    endfunction

    function automatic logic off_ok(input logic [7:0] o);
        return (o >= 8'd1) && (32'(o) < BlockBytes);
    endfunction
endpackage

// ===== hw/rtl/shared_buffer_multi_queue_core.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// in      | in  | i_valid / o_ready  | i_mode, i_queue_handle, i_data_byte
// out     | out | o_valid / i_ready  | o_status, o_read_byte, o_new_handle
// One item at a time through a sequencer around one byte memory with a registered read
// port and a separate write port; a read passes S_RD and S_WAIT before S_EXEC uses the data,
// a write goes through S_WR. Rejected items stop at the check that fails them and finish
// sooner.
// After reset an init pass writes the free link of each of the NumBlocks blocks; no item is taken then.
// The result waits in an output register; a finished item waits until that register is free.
module shared_buffer_multi_queue_core
    import sbmq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_queue_handle,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_read_byte,
    output logic [7:0]  o_new_handle
);
`include "shared_buffer_multi_queue_core_assert.svh"

    logic [7:0] mem [StoreBytes];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    logic       r_init;
    logic [7:0] r_icnt;
    logic [4:0] r_step, n_step;
    logic [AddrW-1:0] r_addr, n_addr, r_waddr, n_waddr;
    logic [7:0] r_wdata, n_wdata;
    logic [4:0] r_ret, n_ret;
    logic [1:0] r_mode;
    logic [7:0] r_q, r_b;
    logic [7:0] r_fh, n_fh;
    logic [7:0] r_a, n_a, r_c, n_c, r_d, n_d, r_e, n_e;
    logic [7:0] r_cnt, n_cnt;
    t_status    r_st, n_st;
    logic [7:0] r_rd, n_rd, r_nh, n_nh;
    t_status    r_ost;
    logic [7:0] r_ord, r_onh;
    logic       r_ov;
    logic       mem_we;
    logic       take;

    assign o_ready = (r_state == S_IDLE) && !r_init;
    assign take = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_read_byte = r_ord;
    assign o_new_handle = r_onh;
    assign mem_we = r_init || (r_state == S_WR);

    always_ff @(posedge i_clk) begin
        if (r_init) begin
            mem[addr_of(r_icnt, 8'd0)] <= (32'(r_icnt) == NumBlocks - 1) ? EndMark
                                                                       : r_icnt + 8'd1;
        end else if (mem_we) begin
            mem[r_waddr] <= r_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    // Sequencer: r_step selects micro-step; a step reads r_addr (via S_RD), writes (via S_WR)
    // then returns to step r_ret, re-enters S_EXEC directly, or ends in S_OUT.
    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_addr = r_addr;
        n_waddr = r_waddr;
        n_wdata = r_wdata;
        n_ret = r_ret;
        n_fh = r_fh;
        n_a = r_a; n_c = r_c; n_d = r_d; n_e = r_e;
        n_cnt = r_cnt;
        n_st = r_st; n_rd = r_rd; n_nh = r_nh;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_st = StOk; n_rd = '0; n_nh = '0;
                    if (i_mode == ModeCreate) begin
                        if (!blk_ok(r_fh)) begin
                            n_st = StNoMem; n_state = S_OUT;
                        end else begin
                            n_addr = addr_of(r_fh, 8'd0); n_step = 5'd0; n_state = S_RD;
                        end
                    end else if (!blk_ok(i_queue_handle)) begin
                        n_st = StIllegal; n_state = S_OUT;
                    end else if (i_mode == ModeDestroy) begin
                        n_addr = addr_of(i_queue_handle, 8'd0); n_step = 5'd4;
                        n_cnt = '0; n_state = S_RD;
                    end else if (i_mode == ModeEnq) begin
                        n_addr = addr_of(i_queue_handle, 8'd2); n_step = 5'd8;
                        n_state = S_RD;
                    end else begin
                        n_addr = addr_of(i_queue_handle, 8'd4); n_step = 5'd14;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_WAIT;
            S_WAIT: n_state = S_EXEC;
            S_WR: begin
                n_step = r_ret;
                n_state = S_EXEC;
            end
            S_OUT: begin
                if (!r_ov || i_ready) n_state = S_IDLE;
            end
            default: begin
                // S_EXEC: r_rdata holds data of the last read when entered from S_WAIT
                n_state = S_WR;
                unique case (r_step)
                    // create: r_a = link of head free block (second block)
                    5'd0: begin
                        if (!blk_ok(r_rdata)) begin
                            n_st = StNoMem; n_state = S_OUT;
                        end else begin
                            n_a = r_rdata; n_addr = addr_of(r_rdata, 8'd0);
                            n_state = S_RD; n_step = 5'd1;
                        end
                    end
                    5'd1: begin
                        // h = r_fh, f = r_a; new free head = link of f
                        n_c = r_rdata;
                        n_waddr = addr_of(r_a, 8'd0); n_wdata = EndMark; n_ret = 5'd2;
                    end
                    5'd2: begin
                        n_waddr = addr_of(r_fh, 8'd0); n_wdata = r_a; n_ret = 5'd3;
                        n_e = 8'd1;
                    end
                    5'd3: begin
                        // header bytes 1..4
                        unique case (r_e)
                            8'd1, 8'd2: begin
                                n_waddr = addr_of(r_fh, r_e); n_wdata = 8'd1;
                                n_e = r_e + 8'd1; n_ret = 5'd3;
                            end
                            8'd3: begin
                                n_waddr = addr_of(r_fh, r_e); n_wdata = r_a;
                                n_e = r_e + 8'd1; n_ret = 5'd3;
                            end
                            8'd4: begin
                                n_waddr = addr_of(r_fh, r_e); n_wdata = 8'd0;
                                n_e = r_e + 8'd1; n_ret = 5'd3;
                            end
                            default: begin
                                n_nh = r_fh; n_fh = r_c; n_state = S_OUT;
                            end
                        endcase
                    end
                    // destroy: r_a = current block
                    5'd4: begin
                        n_a = r_rdata;
                        n_step = 5'd5; n_state = S_EXEC;
                    end
                    5'd5: begin
                        if (blk_ok(r_a) && 32'(r_cnt) < NumBlocks) begin
                            n_addr = addr_of(r_a, 8'd0); n_step = 5'd6; n_state = S_RD;
                        end else begin
                            n_waddr = addr_of(r_q, 8'd0); n_wdata = r_fh;
                            n_fh = r_q; n_ret = 5'd7;
                        end
                    end
                    5'd6: begin
                        n_c = r_rdata;
                        n_waddr = addr_of(r_a, 8'd0); n_wdata = r_fh; n_fh = r_a;
                        n_a = r_rdata; n_cnt = r_cnt + 8'd1; n_ret = 5'd5;
                    end
                    5'd7: n_state = S_OUT;
                    // enqueue: read toff, then tblk
                    5'd8: begin
                        n_c = r_rdata; n_addr = addr_of(r_q, 8'd3);
                        n_step = 5'd9; n_state = S_RD;
                    end
                    5'd9: begin
                        n_a = r_rdata;
                        if (!blk_ok(r_rdata) || !off_ok(r_c)) begin
                            n_st = StIllegal; n_state = S_OUT;
                        end else if (32'(r_c) + 1 == BlockBytes && !blk_ok(r_fh)) begin
                            n_st = StNoMem; n_state = S_OUT;
                        end else begin
                            n_waddr = addr_of(r_rdata, r_c); n_wdata = r_b; n_ret = 5'd10;
                        end
                    end
                    5'd10: begin
                        n_waddr = addr_of(r_q, 8'd4); n_wdata = 8'd1;
                        if (32'(r_c) + 1 == BlockBytes) begin
                            n_ret = 5'd11;
                        end else begin
                            n_c = r_c + 8'd1; n_ret = 5'd13;
                        end
                    end
                    5'd11: begin
                        // take block: read link of free head
                        n_addr = addr_of(r_fh, 8'd0); n_step = 5'd12; n_state = S_RD;
                    end
                    5'd12: begin
                        n_d = r_fh; n_fh = r_rdata;
                        n_waddr = addr_of(r_fh, 8'd0); n_wdata = EndMark;
                        n_c = 8'd1; n_e = 8'd0; n_ret = 5'd21;
                    end
                    5'd21: begin
                        if (r_e == 8'd0) begin
                            n_waddr = addr_of(r_a, 8'd0); n_wdata = r_d;
                            n_e = 8'd1; n_ret = 5'd21;
                        end else begin
                            n_waddr = addr_of(r_q, 8'd3); n_wdata = r_d; n_ret = 5'd13;
                        end
                    end
                    5'd13: begin
                        n_waddr = addr_of(r_q, 8'd2); n_wdata = r_c; n_ret = 5'd7;
                    end
                    // dequeue: flag, hblk, hoff
                    5'd14: begin
                        n_e = r_rdata; n_addr = addr_of(r_q, 8'd0);
                        n_step = 5'd15; n_state = S_RD;
                    end
                    5'd15: begin
                        n_a = r_rdata; n_addr = addr_of(r_q, 8'd1);
                        n_step = 5'd16; n_state = S_RD;
                    end
                    5'd16: begin
                        n_c = r_rdata;
                        if (r_e == 8'd0 || !blk_ok(r_a) || !off_ok(r_rdata)) begin
                            n_st = StIllegal; n_state = S_OUT;
                        end else begin
                            n_addr = addr_of(r_a, r_rdata); n_step = 5'd17; n_state = S_RD;
                        end
                    end
                    5'd17: begin
                        n_rd = r_rdata; n_addr = addr_of(r_q, 8'd3);
                        n_step = 5'd18; n_state = S_RD;
                    end
                    5'd18: begin
                        // r_rdata = tail block
                        n_e = r_rdata;
                        if (32'(r_c) + 1 == BlockBytes) begin
                            n_c = 8'd1;
                            if (r_a != r_rdata) begin
                                n_addr = addr_of(r_a, 8'd0); n_step = 5'd19; n_state = S_RD;
                            end else begin
                                n_step = 5'd22; n_state = S_EXEC;
                            end
                        end else begin
                            n_c = r_c + 8'd1; n_step = 5'd22; n_state = S_EXEC;
                        end
                    end
                    5'd19: begin
                        n_d = r_rdata;
                        n_waddr = addr_of(r_a, 8'd0); n_wdata = r_fh; n_fh = r_a;
                        n_ret = 5'd20;
                    end
                    5'd20: begin
                        n_a = r_d;
                        n_waddr = addr_of(r_q, 8'd0); n_wdata = r_d; n_ret = 5'd22;
                    end
                    5'd22: begin
                        n_waddr = addr_of(r_q, 8'd1); n_wdata = r_c; n_ret = 5'd23;
                    end
                    5'd23: begin
                        n_addr = addr_of(r_q, 8'd2); n_step = 5'd24; n_state = S_RD;
                    end
                    5'd24: begin
                        if (r_c == r_rdata && r_a == r_e) begin
                            n_waddr = addr_of(r_q, 8'd4); n_wdata = 8'd0; n_ret = 5'd7;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_init <= 1'b1;
            r_icnt <= '0;
            r_fh <= '0;
            r_ov <= 1'b0;
            r_step <= '0;
            r_ret <= '0;
        end else begin
            if (r_init) begin
                r_icnt <= r_icnt + 8'd1;
                if (32'(r_icnt) == NumBlocks - 1) r_init <= 1'b0;
            end
            r_state <= n_state;
            r_step <= n_step;
            r_ret <= n_ret;
            r_fh <= n_fh;
            if (r_state == S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr; r_waddr <= n_waddr; r_wdata <= n_wdata;
        r_a <= n_a; r_c <= n_c; r_d <= n_d; r_e <= n_e; r_cnt <= n_cnt;
        if (take) begin
            r_mode <= i_mode; r_q <= i_queue_handle; r_b <= i_data_byte;
        end
        r_st <= n_st; r_rd <= n_rd; r_nh <= n_nh;
        if (r_state == S_OUT && (!r_ov || i_ready)) begin
            r_ost <= r_st; r_ord <= r_rd; r_onh <= r_nh;
        end
    end

    `SBMQ_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE, "ready outside idle")
    `SBMQ_ASSERT_IMP(a_no_init_work, i_clk, i_rst_n, r_init, r_state == S_IDLE, "busy during init")
    `SBMQ_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, take, !o_ready, "ready right after take")
    `SBMQ_ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_valid, o_status != 2'd3, "bad status")
    `SBMQ_ASSERT_IMP(a_mode_held, i_clk, i_rst_n, r_state == S_EXEC && r_step == 5'd9,
        r_mode == ModeEnq, "enqueue step outside enqueue")
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import sbmq_pkg::*;

    typedef struct {
        logic [1:0] status;
        logic [7:0] rd;
        logic [7:0] nh;
    } result_t;

    class queue_scoreboard;
        logic [7:0] mem[StoreBytes];
        bit         wm[StoreBytes];
        logic [7:0] fhead;
        result_t    exp_q[$];
        int         errors;

        function int ad(int b, int o);
            return (b * BlockBytes + o) % StoreBytes;
        endfunction

        function void put(int a, logic [7:0] v);
            mem[a] = v;
            wm[a] = 1;
        endfunction

        function void init();
            for (int i = 0; i < StoreBytes; i++) begin
                mem[i] = '0;
                wm[i] = 0;
            end
            for (int i = 0; i < NumBlocks; i++)
                put(ad(i, 0), (i == NumBlocks - 1) ? EndMark : 8'(i + 1));
            fhead = '0;
            errors = 0;
        endfunction

        function bit bok(int b);
            return b < NumBlocks;
        endfunction

        function bit ook(int o);
            return o >= 1 && o < BlockBytes;
        endfunction

        function int free2();
            if (!bok(fhead)) return 0;
            if (!bok(mem[ad(fhead, 0)])) return 1;
            return 2;
        endfunction

        function int take();
            int idx;
            idx = fhead;
            fhead = mem[ad(idx, 0)];
            put(ad(idx, 0), EndMark);
            return idx;
        endfunction

        function void give(int idx);
            put(ad(idx, 0), fhead);
            fhead = 8'(idx);
        endfunction

        // true if the operation reads only bytes that were written
        function bit safe(t_mode m, int q);
            int hb, ho;
            if (!bok(q) || m == ModeCreate || m == ModeDestroy) return 1;
            for (int o = 0; o < 5; o++)
                if (!wm[ad(q, o)]) return 0;
            if (m == ModeDeq) begin
                hb = mem[ad(q, 0)];
                ho = mem[ad(q, 1)];
                if (mem[ad(q, 4)] != 0 && bok(hb) && ook(ho) && !wm[ad(hb, ho)]) return 0;
            end
            return 1;
        endfunction

        function result_t note(t_mode m, logic [7:0] q, logic [7:0] d);
            result_t r;
            int h, f, blk, nxt, toff, tblk, hblk, hoff;
            r.status = StOk;
            r.rd = '0;
            r.nh = '0;
            if (m == ModeCreate) begin
                if (free2() < 2) begin
                    r.status = StNoMem;
                end else begin
                    h = take();
                    f = take();
                    put(ad(h, 0), 8'(f));
                    put(ad(h, 1), 8'd1);
                    put(ad(h, 2), 8'd1);
                    put(ad(h, 3), 8'(f));
                    put(ad(h, 4), 8'd0);
                    r.nh = 8'(h);
                end
            end else if (!bok(q)) begin
                r.status = StIllegal;
            end else if (m == ModeDestroy) begin
                blk = mem[ad(q, 0)];
                for (int n = 0; n < NumBlocks && bok(blk); n++) begin
                    nxt = mem[ad(blk, 0)];
                    give(blk);
                    blk = nxt;
                end
                give(q);
            end else if (m == ModeEnq) begin
                toff = mem[ad(q, 2)];
                tblk = mem[ad(q, 3)];
                if (!bok(tblk) || !ook(toff)) begin
                    r.status = StIllegal;
                end else if (toff + 1 == BlockBytes && free2() == 0) begin
                    r.status = StNoMem;
                end else begin
                    put(ad(tblk, toff), d);
                    put(ad(q, 4), 8'd1);
                    toff++;
                    if (toff == BlockBytes) begin
                        nxt = take();
                        put(ad(tblk, 0), 8'(nxt));
                        put(ad(q, 3), 8'(nxt));
                        toff = 1;
                    end
                    put(ad(q, 2), 8'(toff));
                end
            end else begin
                hblk = mem[ad(q, 0)];
                hoff = mem[ad(q, 1)];
                if (mem[ad(q, 4)] == 0 || !bok(hblk) || !ook(hoff)) begin
                    r.status = StIllegal;
                end else begin
                    r.rd = mem[ad(hblk, hoff)];
                    hoff++;
                    if (hoff == BlockBytes) begin
                        if (hblk != mem[ad(q, 3)]) begin
                            nxt = mem[ad(hblk, 0)];
                            give(hblk);
                            hblk = nxt;
                            put(ad(q, 0), 8'(hblk));
                        end
                        hoff = 1;
                    end
                    put(ad(q, 1), 8'(hoff));
                    if (hoff == mem[ad(q, 2)] && hblk == mem[ad(q, 3)])
                        put(ad(q, 4), 8'd0);
                end
            end
            exp_q.push_back(r);
            return r;
        endfunction

        task report(string s);
            $display("MISMATCH: %s", s);
            errors++;
        endtask

        task check(result_t got);
            result_t e;
            if (exp_q.size() == 0) begin
                report("result with no item pending");
                return;
            end
            e = exp_q.pop_front();
            if (got.status != e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.rd != e.rd)
                report($sformatf("read_byte %0d, want %0d", got.rd, e.rd));
            if (got.nh != e.nh)
                report($sformatf("new_handle %0d, want %0d", got.nh, e.nh));
        endtask
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [1:0] i_mode = ModeCreate;
    logic [7:0] i_queue_handle = 0;
    logic [7:0] i_data_byte = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [1:0] o_status;
    logic [7:0] o_read_byte;
    logic [7:0] o_new_handle;

    shared_buffer_multi_queue_core uut (.*);

    always #10 i_clk = ~i_clk;

    queue_scoreboard sb = new();
    int      snd_pct = 0;
    int      rcv_pct = 0;
    bit      hold_req = 0;
    int      hold_left = 0;
    int      live[$];
    bit      ever[NumBlocks];
    result_t last;

    always @(posedge i_clk) begin
        result_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.status = o_status;
            got.rd = o_read_byte;
            got.nh = o_new_handle;
            sb.check(got);
        end
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else begin
            i_ready <= $urandom_range(99) >= rcv_pct;
        end
    end

    task automatic send(t_mode m, logic [7:0] q, logic [7:0] d);
        int idx[$];
        if (!sb.safe(m, q)) q = 8'hFF;
        i_valid <= 1;
        i_mode <= m;
        i_queue_handle <= q;
        i_data_byte <= d;
        do @(posedge i_clk); while (!o_ready);
        last = sb.note(m, q, d);
        if (m == ModeCreate && last.status == StOk) begin
            live.push_back(last.nh);
            ever[last.nh] = 1;
        end
        if (m == ModeDestroy && last.status == StOk) begin
            idx = live.find_first_index(x) with (x == q);
            if (idx.size() > 0) live.delete(idx[0]);
        end
        if ($urandom_range(99) < snd_pct) begin
            i_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_pct);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int r, q;
        r = $urandom_range(99);
        q = (live.size() != 0) ? live[$urandom_range(live.size() - 1)] : 0;
        if (live.size() == 0 || (r < 15 && live.size() < 20)) begin
            send(ModeCreate, 8'($urandom), 8'($urandom));
        end else if (r < 22 || live.size() >= 20 && r < 15) begin
            send(ModeDestroy, 8'(q), 8'($urandom));
        end else if (r < 62) begin
            send(ModeEnq, 8'(q), 8'($urandom));
        end else if (r < 95) begin
            send(ModeDeq, 8'(q), 8'($urandom));
        end else if (r < 97) begin
            send(t_mode'($urandom_range(1, 3)), 8'hFF, 8'($urandom));
        end else begin
            q = 8'hFF;
            for (int t = 0; t < 20; t++) begin
                r = $urandom_range(NumBlocks - 1);
                if (ever[r] && !(r inside {live})) begin
                    q = r;
                    break;
                end
            end
            send($urandom_range(1) ? ModeEnq : ModeDeq, 8'(q), 8'($urandom));
        end
    endtask

    initial begin
        int h;
        sb.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        send(ModeCreate, 8'h00, 8'h00);
        h = live[0];
        send(ModeDeq, 8'(h), 8'h00);
        send(ModeEnq, 8'(h), 8'h00);
        send(ModeEnq, 8'(h), 8'hFF);
        send(ModeEnq, 8'(h), 8'hA5);
        send(ModeDeq, 8'(h), 8'h00);
        send(ModeDeq, 8'(h), 8'hFF);
        send(ModeDeq, 8'(h), 8'h00);
        send(ModeDeq, 8'(h), 8'h00);
        send(ModeDestroy, 8'hFF, 8'h00);
        send(ModeEnq, 8'hFF, 8'hFF);
        send(ModeDeq, 8'hFF, 8'h00);
        send(ModeDestroy, 8'(h), 8'h00);
        drain();

        // fill memory with queues, then exhaust it through enqueue
        do send(ModeCreate, 8'($urandom), 8'($urandom)); while (last.status == StOk);
        h = live[0];
        for (int i = 0; i < 2 * (BlockBytes - 1); i++) send(ModeEnq, 8'(h), 8'($urandom));
        for (int i = 0; i < 2 * (BlockBytes - 1); i++) send(ModeDeq, 8'(h), 8'($urandom));
        while (live.size() != 0) send(ModeDestroy, 8'(live[0]), 8'($urandom));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            snd_pct = (ph == 1) ? 86 : (ph == 3) ? 33 : 0;
            rcv_pct = (ph == 2) ? 86 : (ph == 3) ? 33 : 0;
            if (ph == 0) hold_req = 1;
            for (int i = 0; i < 90; i++) random_item();
            drain();
        end
        snd_pct = 0;
        rcv_pct = 0;
        for (int i = 0; i < 40; i++) random_item();
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end
endmodule
